FILE: sv/json_object_stream_framer_top_macros.svh
// Assertion macros used by the framer core (jsof_core).
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef JSON_OBJECT_STREAM_FRAMER_TOP_MACROS_SVH
`define JSON_OBJECT_STREAM_FRAMER_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define JSOF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define JSOF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/jsof_pkg.sv
package jsof_pkg;

   localparam int unsigned ByteW    = 8;
   localparam int unsigned LenW     = 12;
   localparam int unsigned AgeW     = 16;
   localparam int unsigned CsrIdxW  = 1;
   localparam int unsigned CsrDataW = 16;

   localparam logic [LenW-1:0] MaxLenReset  = 12'd511;
   localparam logic [AgeW-1:0] TimeoutReset = 16'd1000;

   localparam logic [ByteW-1:0] ChOpen   = 8'h7B;
   localparam logic [ByteW-1:0] ChClose  = 8'h7D;
   localparam logic [ByteW-1:0] ChQuote  = 8'h22;
   localparam logic [ByteW-1:0] ChBslash = 8'h5C;

   typedef enum logic {
      MODE_DATA = 1'b0,
      MODE_TICK = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DATA     = 2'd0,
      STATUS_TOO_LONG = 2'd1,
      STATUS_TIMEOUT  = 2'd2
   } status_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_MAX_OBJECT_LEN     = 1'b0,
      CSR_OPEN_TIMEOUT_TICKS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic             mode;
      logic [ByteW-1:0] byte_in;
   } req_type;

   typedef struct packed {
      logic [ByteW-1:0] byte_out;
      logic             first_byte;
      logic             last_byte;
      status_type       status;
   } rsp_type;

endpackage

FILE: sv/jsof_core.sv
`include "json_object_stream_framer_top_macros.svh"

module jsof_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  jsof_pkg::req_type              item,
   input  logic [jsof_pkg::LenW-1:0]      max_len,
   input  logic [jsof_pkg::AgeW-1:0]      timeout,
   output logic                           res_valid,
   output jsof_pkg::rsp_type              res
);

   logic                        object_open_ff, object_open_in;
   logic                        inside_string_ff, inside_string_in;
   logic                        escape_pending_ff, escape_pending_in;
   logic [jsof_pkg::LenW-1:0]   nest_depth_ff, nest_depth_in;
   logic [jsof_pkg::LenW-1:0]   object_length_ff, object_length_in;
   logic [jsof_pkg::AgeW-1:0]   open_age_ff, open_age_in;

   logic [jsof_pkg::AgeW-1:0]   age_inc;
   logic [jsof_pkg::LenW:0]     len_plus;
   logic [jsof_pkg::LenW-1:0]   depth_dec;
   logic                        closing;

   always_ff @(posedge clock) begin
      if (reset) begin
         object_open_ff    <= 1'b0;
         inside_string_ff  <= 1'b0;
         escape_pending_ff <= 1'b0;
         nest_depth_ff     <= '0;
         object_length_ff  <= '0;
         open_age_ff       <= '0;
      end else begin
         object_open_ff    <= object_open_in;
         inside_string_ff  <= inside_string_in;
         escape_pending_ff <= escape_pending_in;
         nest_depth_ff     <= nest_depth_in;
         object_length_ff  <= object_length_in;
         open_age_ff       <= open_age_in;
      end
   end

   assign age_inc   = (open_age_ff == '1) ? open_age_ff : open_age_ff + 1'b1;
   assign len_plus  = {1'b0, object_length_ff} + 1'b1;
   assign depth_dec = nest_depth_ff - 1'b1;

   always_comb begin
      object_open_in    = object_open_ff;
      inside_string_in  = inside_string_ff;
      escape_pending_in = escape_pending_ff;
      nest_depth_in     = nest_depth_ff;
      object_length_in  = object_length_ff;
      open_age_in       = open_age_ff;
      res_valid         = 1'b0;
      res.byte_out      = item.byte_in;
      res.first_byte    = 1'b0;
      res.last_byte     = 1'b0;
      res.status        = jsof_pkg::STATUS_DATA;
      closing           = 1'b0;

      if (fire) begin
         priority if (item.mode == jsof_pkg::MODE_TICK) begin
            if (object_open_ff) begin
               if (age_inc > timeout) begin
                  object_open_in    = 1'b0;
                  inside_string_in  = 1'b0;
                  escape_pending_in = 1'b0;
                  nest_depth_in     = '0;
                  object_length_in  = '0;
                  open_age_in       = '0;
                  res_valid         = 1'b1;
                  res.byte_out      = '0;
                  res.last_byte     = 1'b1;
                  res.status        = jsof_pkg::STATUS_TIMEOUT;
               end else begin
                  open_age_in = age_inc;
               end
            end
         end else if (!object_open_ff) begin
            // Hunting: only an opening brace starts an object.
            if (item.byte_in == jsof_pkg::ChOpen) begin
               object_open_in    = 1'b1;
               inside_string_in  = 1'b0;
               escape_pending_in = 1'b0;
               nest_depth_in     = jsof_pkg::LenW'(1);
               object_length_in  = jsof_pkg::LenW'(1);
               open_age_in       = '0;
               res_valid         = 1'b1;
               res.first_byte    = 1'b1;
            end
         end else if (len_plus > {1'b0, max_len}) begin
            // The byte that would overrun the cap is swallowed.
            object_open_in    = 1'b0;
            inside_string_in  = 1'b0;
            escape_pending_in = 1'b0;
            nest_depth_in     = '0;
            object_length_in  = '0;
            open_age_in       = '0;
            res_valid         = 1'b1;
            res.byte_out      = '0;
            res.last_byte     = 1'b1;
            res.status        = jsof_pkg::STATUS_TOO_LONG;
         end else begin
            object_length_in = len_plus[jsof_pkg::LenW-1:0];
            if (inside_string_ff) begin
               priority if (escape_pending_ff) begin
                  escape_pending_in = 1'b0;
               end else if (item.byte_in == jsof_pkg::ChBslash) begin
                  escape_pending_in = 1'b1;
               end else if (item.byte_in == jsof_pkg::ChQuote) begin
                  inside_string_in = 1'b0;
               end else begin
                  inside_string_in = inside_string_ff;
               end
            end else begin
               priority if (item.byte_in == jsof_pkg::ChQuote) begin
                  inside_string_in = 1'b1;
               end else if (item.byte_in == jsof_pkg::ChOpen) begin
                  nest_depth_in = nest_depth_ff + 1'b1;
               end else if (item.byte_in == jsof_pkg::ChClose) begin
                  nest_depth_in = depth_dec;
                  closing       = (depth_dec == '0);
               end else begin
                  nest_depth_in = nest_depth_ff;
               end
            end
            res_valid     = 1'b1;
            res.last_byte = closing;
            if (closing) begin
               object_open_in    = 1'b0;
               inside_string_in  = 1'b0;
               escape_pending_in = 1'b0;
               nest_depth_in     = '0;
               object_length_in  = '0;
               open_age_in       = '0;
            end
         end
      end
   end

   `JSOF_ASSERT_NOW(a_hunt_clear, !object_open_ff,
      (nest_depth_ff == '0) && (object_length_ff == '0) && (open_age_ff == '0)
      && !inside_string_ff && !escape_pending_ff,
      "framer state not cleared while hunting")
   `JSOF_ASSERT_NOW(a_depth_bound, object_open_ff,
      (nest_depth_ff != '0) && (nest_depth_ff <= object_length_ff),
      "nesting depth out of bounds for the open object")
   `JSOF_ASSERT_NOW(a_abort_shape, res_valid && (res.status != jsof_pkg::STATUS_DATA),
      res.last_byte && (res.byte_out == '0) && !res.first_byte,
      "abort result malformed")
   `JSOF_ASSERT_NEXT(a_last_hunts, res_valid && res.last_byte,
      !object_open_ff,
      "object still open after its last item")

endmodule

FILE: sv/jsof_out_reg.sv
module jsof_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  jsof_pkg::rsp_type load_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output jsof_pkg::rsp_type rsp_payload
);

   logic              valid_ff, valid_in;
   jsof_pkg::rsp_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

FILE: sv/json_object_stream_framer_top.sv
// JSON object stream framer.
// The req channel carries one item per handshake: either a received byte
// (mode data) or a time tick (mode tick). Bytes outside an object are dropped;
// an opening brace starts an object, and every object byte leaves on the rsp
// channel, with first_byte on the opening brace and last_byte on the brace
// that closes the outermost level. Braces inside quoted strings do not count.
// An object longer than max_object_len bytes, or open for more than
// open_timeout_ticks ticks, ends in an abort item with status too long or
// timeout; the consumer then drops the partial object.
// The csr channel writes register 0 (max_object_len) and 1 (open_timeout_ticks);
// it is always ready and is meant to be used only while the block is idle.
// The req item is held in the input register and its result in the result
// register, which drives rsp_valid. One item per cycle is sustained while
// the receiver keeps up, since the state update between those registers is
// combinational.
// When the receiver stalls, the result register holds its item and the input
// register fills, after which req_ready drops. Reset empties both registers,
// returns to hunting and restores the register defaults 511 and 1000.
module json_object_stream_framer_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  jsof_pkg::req_type                  req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output jsof_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [jsof_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [jsof_pkg::CsrDataW-1:0]      csr_data
);

   logic                        in_valid_ff, in_valid_in;
   jsof_pkg::req_type           in_data_ff, in_data_in;
   logic [jsof_pkg::LenW-1:0]   max_len_ff, max_len_in;
   logic [jsof_pkg::AgeW-1:0]   timeout_ff, timeout_in;
   logic                        fire;
   logic                        res_valid;
   jsof_pkg::rsp_type           res;

   // The held item is processed when the result register is free or draining.
   assign fire      = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_payload;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      max_len_in = max_len_ff;
      timeout_in = timeout_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            jsof_pkg::CSR_MAX_OBJECT_LEN: begin
               max_len_in = csr_data[jsof_pkg::LenW-1:0];
            end
            jsof_pkg::CSR_OPEN_TIMEOUT_TICKS: begin
               timeout_in = csr_data[jsof_pkg::AgeW-1:0];
            end
            default: begin
               max_len_in = max_len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         max_len_ff  <= jsof_pkg::MaxLenReset;
         timeout_ff  <= jsof_pkg::TimeoutReset;
      end else begin
         in_valid_ff <= in_valid_in;
         max_len_ff  <= max_len_in;
         timeout_ff  <= timeout_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   jsof_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (in_data_ff),
      .max_len   (max_len_ff),
      .timeout   (timeout_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   jsof_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (res_valid),
      .load_data   (res),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: tb/sv/tb_json_object_stream_framer_top.sv
module tb_json_object_stream_framer_top;
   import jsof_pkg::*;

   // Clock, reset and every block input start at known values at time zero.
   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   req_type             req_payload = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   rsp_type             rsp_payload;
   logic                csr_valid   = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index   = '0;
   logic [CsrDataW-1:0] csr_data    = '0;

   json_object_stream_framer_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Items waiting to be sent, and framer results still owed by the block.
   req_type pending_items[$];
   rsp_type framed_bytes_due[$];
   int      error_count = 0;

   // The framer's own view of the registers and of the object being framed.
   logic [LenW-1:0]  max_len       = MaxLenReset;
   logic [AgeW-1:0]  timeout_ticks = TimeoutReset;
   logic             obj_open;
   logic             quote_open;
   logic             esc_pending;
   logic [LenW-1:0]  nest_level;
   logic [LenW-1:0]  obj_len;
   logic [AgeW-1:0]  open_age;

   function automatic void start_hunting();
      obj_open    = 1'b0;
      quote_open  = 1'b0;
      esc_pending = 1'b0;
      nest_level  = '0;
      obj_len     = '0;
      open_age    = '0;
   endfunction

   // Advances the framer state by one accepted item. Returns 1 when the item
   // produces a result, which is then placed in framed.
   function automatic bit frame_item(input req_type item, output rsp_type framed);
      logic [LenW:0] grown;
      bit            closing;
      framed.byte_out   = '0;
      framed.first_byte = 1'b0;
      framed.last_byte  = 1'b0;
      framed.status     = STATUS_DATA;
      closing           = 1'b0;

      if (item.mode == MODE_TICK) begin
         // Ticks only age an open object; while hunting they do nothing.
         if (!obj_open) return 1'b0;
         if (open_age != {AgeW{1'b1}}) open_age = open_age + 1'b1;
         if (open_age > timeout_ticks) begin
            start_hunting();
            framed.last_byte = 1'b1;
            framed.status    = STATUS_TIMEOUT;
            return 1'b1;
         end
         return 1'b0;
      end

      if (!obj_open) begin
         if (item.byte_in != ChOpen) return 1'b0;
         obj_open          = 1'b1;
         quote_open        = 1'b0;
         esc_pending       = 1'b0;
         nest_level        = LenW'(1);
         obj_len           = LenW'(1);
         open_age          = '0;
         framed.byte_out   = item.byte_in;
         framed.first_byte = 1'b1;
         return 1'b1;
      end

      // The byte that would overrun the length cap is swallowed by the abort.
      grown = {1'b0, obj_len} + 1'b1;
      if (grown > {1'b0, max_len}) begin
         start_hunting();
         framed.last_byte = 1'b1;
         framed.status    = STATUS_TOO_LONG;
         return 1'b1;
      end
      obj_len = grown[LenW-1:0];

      if (quote_open) begin
         if (esc_pending)                esc_pending = 1'b0;
         else if (item.byte_in == ChBslash) esc_pending = 1'b1;
         else if (item.byte_in == ChQuote)  quote_open  = 1'b0;
      end else if (item.byte_in == ChQuote) begin
         quote_open = 1'b1;
      end else if (item.byte_in == ChOpen) begin
         nest_level = nest_level + 1'b1;
      end else if (item.byte_in == ChClose) begin
         nest_level = nest_level - 1'b1;
         closing    = (nest_level == '0);
      end

      framed.byte_out  = item.byte_in;
      framed.last_byte = closing;
      if (closing) start_hunting();
      return 1'b1;
   endfunction

   // Driver. It sends the queued items in bursts of random length with random
   // gaps between them. An item stays on the bus until it is accepted, and
   // the framer state is advanced at the edge that accepts it.
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : driver
      rsp_type framed;
      if (reset) begin
         req_valid <= 1'b0;
         start_hunting();
      end else begin
         if (req_valid && req_ready) begin
            if (frame_item(req_payload, framed)) framed_bytes_due.push_back(framed);
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_payload <= pending_items.pop_front();
               req_valid   <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 32);
                  // Many bursts run straight into the next one; a few gaps
                  // are long enough to let the block drain completely.
                  case ($urandom_range(0, 9))
                     0, 1, 2, 3: gap_left = 0;
                     4:          gap_left = $urandom_range(9, 40);
                     default:    gap_left = $urandom_range(1, 8);
                  endcase
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Register writes take effect in the framer view at the accepting edge.
   always @(posedge clock) begin
      if (reset) begin
         max_len       = MaxLenReset;
         timeout_ticks = TimeoutReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_OBJECT_LEN:     max_len       = csr_data[LenW-1:0];
            CSR_OPEN_TIMEOUT_TICKS: timeout_ticks = csr_data[AgeW-1:0];
         endcase
      end
   end

   // Monitor. The receiver's ready follows a 16-bit pattern that rotates
   // every cycle and is swapped at random intervals for another one:
   // always ready, random, mostly stalled or a regular on/off rhythm.
   logic [15:0] ready_pattern = 16'hFFFF;
   int          pattern_left  = 0;

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (framed_bytes_due.size() == 0) begin
               $display("%0t: unexpected result: byte_out=%h first=%b last=%b status=%0d",
                        $time, rsp_payload.byte_out, rsp_payload.first_byte,
                        rsp_payload.last_byte, rsp_payload.status);
               error_count++;
            end else begin
               want = framed_bytes_due.pop_front();
               if (rsp_payload.byte_out !== want.byte_out ||
                   rsp_payload.first_byte !== want.first_byte ||
                   rsp_payload.last_byte !== want.last_byte ||
                   rsp_payload.status !== want.status) begin
                  $display("%0t: mismatch: expected byte_out=%h first=%b last=%b status=%0d, %s",
                           $time, want.byte_out, want.first_byte, want.last_byte,
                           want.status, "got:");
                  $display("%0t:           actual   byte_out=%h first=%b last=%b status=%0d",
                           $time, rsp_payload.byte_out, rsp_payload.first_byte,
                           rsp_payload.last_byte, rsp_payload.status);
                  error_count++;
               end
            end
         end
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(32, 256);
            case ($urandom_range(0, 3))
               0: ready_pattern = 16'hFFFF;
               1: ready_pattern = 16'($urandom());
               2: ready_pattern = 16'h0101;
               3: ready_pattern = 16'hF0F0;
            endcase
         end else begin
            pattern_left--;
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
         end
         rsp_ready <= ready_pattern[0];
      end
   end

   task automatic push_byte(input logic [ByteW-1:0] value);
      req_type item;
      item.mode    = MODE_DATA;
      item.byte_in = value;
      pending_items.push_back(item);
   endtask

   // The byte field of a tick carries garbage, since the block ignores it.
   task automatic push_tick();
      req_type item;
      item.mode    = MODE_TICK;
      item.byte_in = 8'($urandom_range(0, 255));
      pending_items.push_back(item);
   endtask

   // Generates one JSON-like object with random content: nested braces,
   // quoted strings with escapes and stray braces, separators, arbitrary
   // bytes and ticks. The object is cut short when it reaches byte_budget,
   // which leaves it open for the length cap or the timeout to end.
   task automatic add_object(input int byte_budget, output int produced);
      int level;
      bit quoted;
      level    = 1;
      quoted   = 1'b0;
      produced = 1;
      push_byte(ChOpen);
      while (level > 0 && produced < byte_budget) begin
         produced++;
         if ($urandom_range(0, 9) == 0) begin
            push_tick();
         end else if (quoted) begin
            case ($urandom_range(0, 9))
               0: begin
                  push_byte(ChBslash);
                  push_byte($urandom_range(0, 1) ? ChQuote : 8'($urandom_range(0, 255)));
                  produced++;
               end
               1:       begin push_byte(ChQuote); quoted = 1'b0; end
               2:       push_byte(ChOpen);
               3:       push_byte(ChClose);
               4:       push_byte(8'($urandom_range(0, 255)));
               default: push_byte(8'($urandom_range(8'h61, 8'h7A)));
            endcase
         end else begin
            case ($urandom_range(0, 11))
               0, 1: begin push_byte(ChQuote); quoted = 1'b1; end
               2, 3: begin
                  if (level < 6) begin
                     push_byte(ChOpen);
                     level++;
                  end else begin
                     push_byte(8'h3A);
                  end
               end
               4, 5, 6: begin push_byte(ChClose); level--; end
               7:       push_byte(ChBslash);
               8:       push_byte(8'h3A);
               9:       push_byte(8'h2C);
               default: push_byte(8'($urandom_range(0, 255)));
            endcase
         end
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CsrDataW-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Waits until every item has been sent and every result has come back.
   // A trailing item that produces no result may still be inside the block,
   // so the task lets it pass through before returning.
   task automatic wait_drained();
      @(posedge clock);
      while (pending_items.size() != 0 || req_valid || framed_bytes_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Stimulus sequence. A short directed part first, under the reset register
   // values and then under the smallest caps, followed by random phases that
   // each run under their own register setting.
   initial begin : stimulus
      int phase;
      int made;
      int phase_items;
      int budget;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset values (511 bytes, 1000 ticks). Noise and a tick while hunting,
      // a stray closing brace, then an object whose string holds a brace, an
      // escaped quote and a closing brace, a backslash outside any string, a
      // nested object with a tick inside it, and the final closing brace.
      push_tick();
      push_byte(8'h61);
      push_byte(ChClose);
      push_byte(ChOpen);
      push_byte(ChQuote);
      push_byte(ChOpen);
      push_byte(ChBslash);
      push_byte(ChQuote);
      push_byte(ChClose);
      push_byte(ChQuote);
      push_byte(ChBslash);
      push_byte(ChOpen);
      push_tick();
      push_byte(ChClose);
      push_byte(ChClose);
      wait_drained();

      // Smallest legal cap and a zero timeout: an empty object fits exactly,
      // the third byte of a longer one aborts and is not taken as a new
      // opening brace, and the first tick inside an object aborts it.
      write_reg(CSR_MAX_OBJECT_LEN, 16'd2);
      write_reg(CSR_OPEN_TIMEOUT_TICKS, 16'd0);
      push_byte(ChOpen);
      push_byte(ChClose);
      push_byte(ChOpen);
      push_byte(8'h61);
      push_byte(ChOpen);
      push_byte(ChOpen);
      push_tick();
      wait_drained();

      // A cap of zero, written with the unused upper data bits set, makes the
      // second byte abort. The timeout at its maximum never expires, so the
      // next object stays open through its ticks into the following setting.
      write_reg(CSR_MAX_OBJECT_LEN, 16'hF000);
      write_reg(CSR_OPEN_TIMEOUT_TICKS, 16'hFFFF);
      push_byte(ChOpen);
      push_byte(8'h78);
      push_byte(ChOpen);
      push_tick();
      push_tick();
      wait_drained();

      // A cap of one and a timeout of one: the open object is already past
      // the new timeout, so its next tick aborts; a new object then aborts
      // on its second byte.
      write_reg(CSR_MAX_OBJECT_LEN, 16'd1);
      write_reg(CSR_OPEN_TIMEOUT_TICKS, 16'd1);
      push_tick();
      push_byte(ChOpen);
      push_byte(ChClose);
      wait_drained();

      // Random phases. Most items belong to objects; the noise between them is
      // ignored unless it holds an opening brace, and is not counted toward a phase.
      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_MAX_OBJECT_LEN, 16'd4095);
               write_reg(CSR_OPEN_TIMEOUT_TICKS, 16'hFFFF);
            end
            1: begin
               write_reg(CSR_MAX_OBJECT_LEN, 16'd2);
               write_reg(CSR_OPEN_TIMEOUT_TICKS, 16'd1);
            end
            2: begin
               write_reg(CSR_MAX_OBJECT_LEN, 16'($urandom_range(3, 24)));
               write_reg(CSR_OPEN_TIMEOUT_TICKS, 16'($urandom_range(1, 12)));
            end
            3: begin
               write_reg(CSR_MAX_OBJECT_LEN, 16'(MaxLenReset));
               write_reg(CSR_OPEN_TIMEOUT_TICKS, 16'($urandom_range(20, 200)));
            end
            4: begin
               write_reg(CSR_MAX_OBJECT_LEN, 16'($urandom_range(3, 80)));
               write_reg(CSR_OPEN_TIMEOUT_TICKS, 16'd0);
            end
            5: begin
               write_reg(CSR_MAX_OBJECT_LEN, 16'($urandom_range(2, 4095)));
               write_reg(CSR_OPEN_TIMEOUT_TICKS, 16'($urandom_range(1, 65535)));
            end
            default: begin
               write_reg(CSR_MAX_OBJECT_LEN, 16'($urandom_range(3, 40)));
               write_reg(CSR_OPEN_TIMEOUT_TICKS, 16'($urandom_range(2, 30)));
            end
         endcase

         phase_items = 0;
         while (phase_items < 175) begin
            repeat ($urandom_range(0, 3)) begin
               if ($urandom_range(0, 2) == 0) push_tick();
               else push_byte(8'($urandom_range(0, 255)));
            end
            budget = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 300)
                                                  : $urandom_range(2, 40);
            add_object(budget, made);
            phase_items += made;
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog for a block that hangs; far beyond the slowest correct run.
   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
